// ===== rtl/iidl_pkg.sv =====
package iidl_pkg;

  localparam int KIND_W  = 2;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== rtl/indexed_insert_delete_list.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in one synchronous
// RAM with a single write and a single read port. Every transaction gives a
// result: append, insert, delete and a dump of an empty list give one, and a
// dump of a non-empty list gives one per entry, the last one flagged. Status,
// emptiness and count are known at acceptance, so the single result of a
// non-dump transaction is registered at the edge that accepts it. The RAM work
// then follows one entry per cycle through a read-ahead pipeline, a dump only
// while the result channel is not stalled: an append or an insert at position i
// rewrites the entries from the old end down to i, a delete at position i moves
// each later entry down by one, and a dump reads every entry in order. An
// ignored transaction does no RAM work. A new transaction is taken only when
// that work is done and the result register can be loaded.
module indexed_insert_delete_list
  import iidl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_entry_value,
  output logic                     out_has_value,
  output logic                     out_is_last,
  output logic                     out_is_empty,
  output logic [CNT_W-1:0]         out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam int OW = (IW > CNT_W) ? IW : CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [VAL_W-1:0]        entries_r [CAPACITY];
  logic signed [VAL_W-1:0] rd_data_r;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;
  logic [CW-1:0]           op_idx_r, op_idx_nxt;
  logic signed [VAL_W-1:0] op_val_r, op_val_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_has_r, out_has_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;

  logic                    can_load;
  logic                    out_load;
  logic                    accept;
  logic                    full;
  logic [IW-1:0]           idx_x;
  logic [IW-1:0]           cnt_x;
  logic [CW-1:0]           idx_c;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [CW-1:0]           ptr_dec;
  logic [CW-1:0]           ptr_dec2;
  logic [CW-1:0]           ptr_inc;
  logic [CW-1:0]           ptr_inc2;
  logic [CW-1:0]           cnt_dec;
  logic [CW-1:0]           idx_inc;
  logic [OW-1:0]           count_out_x;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !can_load;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r >= CW'(CAPACITY);
  assign idx_x    = IW'(in_index);
  assign cnt_x    = IW'(count_r);
  assign idx_c    = idx_x[CW-1:0];
  assign ptr_dec  = ptr_r - CW'(1);
  assign ptr_dec2 = ptr_r - CW'(2);
  assign ptr_inc  = ptr_r + CW'(1);
  assign ptr_inc2 = ptr_r + CW'(2);
  assign cnt_dec  = count_r - CW'(1);
  assign idx_inc  = idx_c + CW'(1);
  assign count_out_x = OW'(count_nxt);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    op_idx_nxt     = op_idx_r;
    op_val_nxt     = op_val_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    out_load       = 1'b0;
    out_status_nxt = STAT_DONE;
    out_value_nxt  = '0;
    out_has_nxt    = 1'b0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_val_nxt = in_value;
          out_load   = 1'b1;
          case (in_kind)
            KIND_APPEND: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                state_nxt  = S_INS;
                ptr_nxt    = count_r;
                op_idx_nxt = count_r;
                count_nxt  = count_r + CW'(1);
              end
            end
            KIND_INSERT: begin
              if (idx_x > cnt_x) begin
                out_status_nxt = STAT_RANGE;
              end else if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                state_nxt  = S_INS;
                ptr_nxt    = count_r;
                op_idx_nxt = idx_c;
                count_nxt  = count_r + CW'(1);
                if (idx_x < cnt_x) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_dec[AW-1:0];
                end
              end
            end
            KIND_DELETE: begin
              if (idx_x >= cnt_x) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                count_nxt = cnt_dec;
                if (idx_inc < count_r) begin
                  state_nxt = S_DEL;
                  ptr_nxt   = idx_c;
                  rd_en     = 1'b1;
                  rd_addr   = idx_inc[AW-1:0];
                end
              end
            end
            default: begin
              if (count_r != '0) begin
                out_load  = 1'b0;
                state_nxt = S_DUMP;
                ptr_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
              end
            end
          endcase
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        if (ptr_r == op_idx_r) begin
          wr_data   = op_val_r;
          state_nxt = S_IDLE;
        end else begin
          wr_data = rd_data_r;
          ptr_nxt = ptr_dec;
          if (ptr_dec > op_idx_r) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[AW-1:0];
          end
        end
      end
      S_DEL: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = rd_data_r;
        if (ptr_inc < count_r) begin
          ptr_nxt = ptr_inc;
          rd_en   = 1'b1;
          rd_addr = ptr_inc2[AW-1:0];
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (can_load) begin
          out_load      = 1'b1;
          out_value_nxt = rd_data_r;
          out_has_nxt   = 1'b1;
          out_last_nxt  = (ptr_inc == count_r);
          if (ptr_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_inc;
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_empty_nxt = (count_nxt == '0);
    out_count_nxt = count_out_x[CNT_W-1:0];
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entries_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    op_idx_r <= op_idx_nxt;
    op_val_r <= op_val_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_has_r    <= out_has_nxt;
      out_last_r   <= out_last_nxt;
      out_empty_r  <= out_empty_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_has_value   = out_has_r;
  assign out_is_last     = out_last_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry in one cycle");

  a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (ptr_r < count_r))
    else $error("dump pointer beyond the list");

  a_value_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_r) |-> !out_empty_r)
    else $error("dumped entry reported from an empty list");

  a_busy_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(count_r))
    else $error("entry count changed while a transaction was in progress");

endmodule

// ===== dv/tb_indexed_insert_delete_list.sv =====
typedef struct packed {
  logic [iidl_pkg::STAT_W-1:0]        status;
  logic signed [iidl_pkg::VAL_W-1:0]  entry_value;
  logic                               has_value;
  logic                               is_last;
  logic                               is_empty;
  logic [iidl_pkg::CNT_W-1:0]         entry_count;
} list_result_t;

class list_scoreboard;
  localparam int CAP = 16;

  logic signed [iidl_pkg::VAL_W-1:0] entries [CAP];
  int                                count;
  list_result_t                      pending_results [$];
  int                                errors;

  function new();
    count = 0;
    errors = 0;
  endfunction

  function void push_result(logic [iidl_pkg::STAT_W-1:0] status,
                            logic signed [iidl_pkg::VAL_W-1:0] entry_value,
                            logic has_value, logic is_last);
    list_result_t r;
    r.status      = status;
    r.entry_value = entry_value;
    r.has_value   = has_value;
    r.is_last     = is_last;
    r.is_empty    = (count == 0);
    r.entry_count = count[iidl_pkg::CNT_W-1:0];
    pending_results.push_back(r);
  endfunction

  function void note_transaction(logic [iidl_pkg::KIND_W-1:0] kind,
                                 logic [iidl_pkg::IDX_W-1:0] index,
                                 logic signed [iidl_pkg::VAL_W-1:0] value);
    logic [iidl_pkg::STAT_W-1:0] status;
    int                          pos;
    status = iidl_pkg::STAT_DONE;
    pos = int'(index);
    case (kind)
      iidl_pkg::KIND_DUMP: begin
        if (count == 0) begin
          push_result(iidl_pkg::STAT_DONE, '0, 1'b0, 1'b1);
        end else begin
          for (int k = 0; k < count; k++) begin
            push_result(iidl_pkg::STAT_DONE, entries[k], 1'b1, k + 1 == count);
          end
        end
        return;
      end
      iidl_pkg::KIND_APPEND: begin
        if (count >= CAP) begin
          status = iidl_pkg::STAT_FULL;
        end else begin
          entries[count] = value;
          count++;
        end
      end
      iidl_pkg::KIND_INSERT: begin
        if (pos > count) begin
          status = iidl_pkg::STAT_RANGE;
        end else if (count >= CAP) begin
          status = iidl_pkg::STAT_FULL;
        end else begin
          for (int k = count; k > pos; k--) begin
            entries[k] = entries[k - 1];
          end
          entries[pos] = value;
          count++;
        end
      end
      default: begin
        if (pos >= count) begin
          status = iidl_pkg::STAT_RANGE;
        end else begin
          for (int k = pos; k + 1 < count; k++) begin
            entries[k] = entries[k + 1];
          end
          count--;
        end
      end
    endcase
    push_result(status, '0, 1'b0, 1'b1);
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d value %0d count %0d",
             got.status, got.entry_value, got.entry_count);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.entry_value !== want.entry_value) begin
      $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
      errors++;
    end
    if (got.has_value !== want.has_value) begin
      $error("has_value: expected %0d, got %0d", want.has_value, got.has_value);
      errors++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
      errors++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errors++;
    end
  endfunction
endclass

module tb_indexed_insert_delete_list;
  import iidl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        in_kind;
  logic [IDX_W-1:0]         in_index;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [VAL_W-1:0]  out_entry_value;
  logic                     out_has_value;
  logic                     out_is_last;
  logic                     out_is_empty;
  logic [CNT_W-1:0]         out_entry_count;

  list_scoreboard list_sb;
  int             cycles;
  bit             sender_quiet;
  int             results_seen;
  bit             held_once;

  indexed_insert_delete_list #(.CAPACITY(16)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_index        (in_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_has_value   (out_has_value),
    .out_is_last     (out_is_last),
    .out_is_empty    (out_is_empty),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] index,
                           input logic signed [VAL_W-1:0] value);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_index <= index;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    list_sb.note_transaction(kind, index, value);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (list_sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_segment(input mix_t mix, input int n_items);
    int                      r;
    int                      cnt;
    int                      t_app;
    int                      t_ins;
    int                      t_del;
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    case (mix)
      MIX_GROW: begin
        t_app = 45; t_ins = 85; t_del = 92;
      end
      MIX_SHRINK: begin
        t_app = 10; t_ins = 22; t_del = 85;
      end
      default: begin
        t_app = 25; t_ins = 50; t_del = 78;
      end
    endcase
    for (int n = 0; n < n_items; n++) begin
      cnt = list_sb.count;
      r = $urandom_range(0, 99);
      if (r < t_app) kind = KIND_APPEND;
      else if (r < t_ins) kind = KIND_INSERT;
      else if (r < t_del) kind = KIND_DELETE;
      else kind = KIND_DUMP;
      if ($urandom_range(0, 9) == 0) begin
        index = IDX_W'($urandom_range(0, 31));
      end else if (kind == KIND_INSERT) begin
        index = IDX_W'($urandom_range(0, cnt));
      end else begin
        index = (cnt > 0) ? IDX_W'($urandom_range(0, cnt - 1)) : '0;
      end
      case ($urandom_range(0, 7))
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = '0;
        default: value = $urandom;
      endcase
      send_item(kind, index, value);
    end
  endtask

  task automatic receive_results();
    int           gap;
    list_result_t got;
    forever begin
      if (!held_once && results_seen >= 60) begin
        gap = HOLD_CYCLES;
        held_once = 1'b1;
      end else if ((results_seen / 40) % 3 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.status      = out_status;
      got.entry_value = out_entry_value;
      got.has_value   = out_has_value;
      got.is_last     = out_is_last;
      got.is_empty    = out_is_empty;
      got.entry_count = out_entry_count;
      list_sb.check_result(got);
      results_seen++;
    end
  endtask

  initial begin
    list_sb = new();
    cycles = 0;
    results_seen = 0;
    held_once = 1'b0;
    sender_quiet = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_kind   <= KIND_APPEND;
    in_index  <= '0;
    in_value  <= '0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      receive_results();
    join_none

    send_item(KIND_DUMP,   5'd0,  32'sd0);
    send_item(KIND_DELETE, 5'd0,  32'sd5);
    send_item(KIND_INSERT, 5'd1,  32'sd7);
    send_item(KIND_INSERT, 5'd0,  32'sh7fffffff);
    send_item(KIND_APPEND, 5'd31, 32'sh80000000);
    send_item(KIND_INSERT, 5'd1,  -32'sd1);
    send_item(KIND_APPEND, 5'd0,  32'sd0);
    send_item(KIND_DELETE, 5'd4,  32'sd0);
    send_item(KIND_INSERT, 5'd31, 32'sh5a5a5a5a);
    send_item(KIND_INSERT, 5'd4,  32'sh1234abcd);
    send_item(KIND_DUMP,   5'd16, 32'sd0);
    send_item(KIND_DELETE, 5'd4,  32'sd0);
    send_item(KIND_DELETE, 5'd0,  32'sd0);
    send_item(KIND_DUMP,   5'd0,  32'sd0);
    wait_for_drain();

    run_segment(MIX_GROW, 30);
    run_segment(MIX_EVEN, 30);
    run_segment(MIX_SHRINK, 30);
    wait_for_drain();
    sender_quiet = 1'b1;
    run_segment(MIX_GROW, 30);
    sender_quiet = 1'b0;
    run_segment(MIX_EVEN, 30);
    run_segment(MIX_SHRINK, 30);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_sb.errors == 0 && list_sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/iidl_pkg.sv
rtl/indexed_insert_delete_list.sv
dv/tb_indexed_insert_delete_list.sv
